>>> rtl/rgc_pkg.sv
`timescale 1ns / 1ps

package rgc_pkg;

	localparam int CH_W        = 8;
	localparam int GAIN_W      = 12;
	localparam int FRAC_W      = 8;
	localparam int NUM_LANES   = 3;
	localparam int PROD_W      = CH_W + GAIN_W;
	localparam int REM_W       = 2 * CH_W;
	localparam int DIV_STEPS   = CH_W;
	localparam int LANE_STAGES = DIV_STEPS + 1;
	localparam int PIPE_DEPTH  = LANE_STAGES + 1;

	typedef logic [CH_W-1:0]        chan_t;
	typedef logic [GAIN_W-1:0]      gain_t;
	typedef chan_t [NUM_LANES-1:0]  chan_vec_t;
	typedef logic [LANE_STAGES:1]   lane_en_t;

	localparam gain_t GAIN_RESET = GAIN_W'(1536);
	localparam chan_t FULL_SCALE = CH_W'(255);
	localparam logic [PROD_W-1:0] LIMIT = PROD_W'(FULL_SCALE) << FRAC_W;

	typedef struct packed {
		logic  ovf;
		chan_t gained;
		chan_t quot;
	} lane_res_t;

	typedef lane_res_t [NUM_LANES-1:0] lane_res_vec_t;

endpackage

>>> rtl/rgc_if.sv
`timescale 1ns / 1ps

interface rgc_pixel_if;
	import rgc_pkg::*;

	logic  valid;
	logic  ready;
	chan_t red_in;
	chan_t green_in;
	chan_t blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
	modport monitor (input valid, input ready, input red_in, input green_in, input blue_in);
endinterface

interface rgc_result_if;
	import rgc_pkg::*;

	logic  valid;
	logic  ready;
	chan_t red_out;
	chan_t green_out;
	chan_t blue_out;
	logic  clamped;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output clamped, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input clamped, output ready);
	modport monitor (input valid, input ready, input red_out, input green_out,
		input blue_out, input clamped);
endinterface

>>> rtl/rgc_lane.sv
`timescale 1ns / 1ps

module rgc_lane (
	input  logic               clk,
	input  rgc_pkg::lane_en_t  en,
	input  rgc_pkg::chan_t     ch,
	input  rgc_pkg::chan_t     m,
	input  rgc_pkg::gain_t     gain,
	output rgc_pkg::lane_res_t res
);
	import rgc_pkg::*;

	logic [PROD_W-1:0] prod;
	logic [REM_W-1:0]  scaled;

	logic [REM_W-1:0] rem_s    [1:LANE_STAGES];
	chan_t            den_s    [1:LANE_STAGES];
	chan_t            quot_s   [1:LANE_STAGES];
	chan_t            gained_s [1:LANE_STAGES];
	logic             ovf_s    [1:LANE_STAGES];

	assign prod   = PROD_W'(ch) * PROD_W'(gain);
	assign scaled = {ch, CH_W'(0)} - REM_W'(ch);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			rem_s[1]    <= scaled;
			den_s[1]    <= m;
			quot_s[1]   <= '0;
			gained_s[1] <= prod[FRAC_W +: CH_W];
			ovf_s[1]    <= (prod > LIMIT);
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar j = 2; j <= LANE_STAGES; j++) begin : g_div
		localparam int K = LANE_STAGES - j;

		logic [REM_W-1:0] trial;
		logic             take;
		chan_t            qbit;

		assign trial = REM_W'(den_s[j-1]) << K;
		assign take  = (rem_s[j-1] >= trial);
		assign qbit  = CH_W'(take) << K;

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j]    <= take ? (rem_s[j-1] - trial) : rem_s[j-1];
				den_s[j]    <= den_s[j-1];
				quot_s[j]   <= quot_s[j-1] | qbit;
				gained_s[j] <= gained_s[j-1];
				ovf_s[j]    <= ovf_s[j-1];
			end
		end
	end

	assign res.ovf    = ovf_s[LANE_STAGES];
	assign res.gained = gained_s[LANE_STAGES];
	assign res.quot   = quot_s[LANE_STAGES];

endmodule

>>> rtl/rgc_merge.sv
`timescale 1ns / 1ps

module rgc_merge (
	input  logic                   clk,
	input  logic                   en,
	input  rgc_pkg::lane_res_vec_t lanes,
	output rgc_pkg::chan_vec_t     chan,
	output logic                   clamped
);
	import rgc_pkg::*;

	logic      clamp_any;
	chan_vec_t chan_q;
	logic      clamped_q;

	always_comb begin
		clamp_any = 1'b0;
		for (int i = 0; i < NUM_LANES; i++) begin
			clamp_any = clamp_any | lanes[i].ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				chan_q[i] <= clamp_any ? lanes[i].quot : lanes[i].gained;
			end
			clamped_q <= clamp_any;
		end
	end

	assign chan    = chan_q;
	assign clamped = clamped_q;

endmodule

>>> rtl/rgb_gain_with_ratio_clamp.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// pixel     in   valid / ready      red_in, green_in, blue_in
// result    out  valid / ready      red_out, green_out, blue_out, clamped
// cfg       in   cfg_we             cfg_wdata (gain, Q4.8)
//
// One pixel per clock is sustained while result.ready is high.
// A result passes through the input stage, the eight-stage divider in each lane and the merge.
// Reset clears the stage valid bits and loads the gain with 6.0; no clearing pass.
// A stalled result holds the output stage, and earlier stages keep filling bubbles.

module rgb_gain_with_ratio_clamp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  rgc_pkg::gain_t  cfg_wdata,
	rgc_pixel_if.sink       pixel,
	rgc_result_if.source    result
);
	import rgc_pkg::*;

	gain_t                 gain_q;
	logic [PIPE_DEPTH:1]   vld_q;
	logic [PIPE_DEPTH:1]   en;
	chan_vec_t             ch;
	chan_t                 m;
	lane_res_vec_t         lanes;
	chan_vec_t             chan;
	logic                  clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	always_comb begin
		logic go;
		go = result.ready;
		for (int k = PIPE_DEPTH; k >= 1; k--) begin
			en[k] = !vld_q[k] || go;
			go    = en[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= pixel.valid;
			end
			for (int k = 2; k <= PIPE_DEPTH; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign pixel.ready = en[1];

	assign ch[0] = pixel.red_in;
	assign ch[1] = pixel.green_in;
	assign ch[2] = pixel.blue_in;

	always_comb begin
		m = (ch[0] > ch[1]) ? ch[0] : ch[1];
		m = (m > ch[2]) ? m : ch[2];
	end

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		rgc_lane u_lane (
			.clk  (clk),
			.en   (en[LANE_STAGES:1]),
			.ch   (ch[i]),
			.m    (m),
			.gain (gain_q),
			.res  (lanes[i])
		);
	end

	rgc_merge u_merge (
		.clk     (clk),
		.en      (en[PIPE_DEPTH]),
		.lanes   (lanes),
		.chan    (chan),
		.clamped (clamped)
	);

	assign result.valid     = vld_q[PIPE_DEPTH];
	assign result.red_out   = chan[0];
	assign result.green_out = chan[1];
	assign result.blue_out  = chan[2];
	assign result.clamped   = clamped;

endmodule

>>> rtl/rgc_checker.sv
`timescale 1ns / 1ps

module rgc_props (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input rgc_pkg::chan_t red_out,
	input rgc_pkg::chan_t green_out,
	input rgc_pkg::chan_t blue_out,
	input logic           clamped
);
	import rgc_pkg::*;

	logic       in_beat;
	logic       out_beat;
	logic [3:0] pend_q;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 4'(in_beat) - 4'(out_beat);
		end
	end

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != 4'd0))
		else $error("result beat without a pending pixel");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'(PIPE_DEPTH))
		else $error("more pixels in flight than pipeline stages");

	a_clamp_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clamped) |->
		(red_out == FULL_SCALE || green_out == FULL_SCALE || blue_out == FULL_SCALE))
		else $error("clamped result has no channel at full scale");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(red_out) && $stable(green_out) &&
		 $stable(blue_out) && $stable(clamped)))
		else $error("stalled result changed");

endmodule

bind rgb_gain_with_ratio_clamp rgc_props u_rgc_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.red_out   (result.red_out),
	.green_out (result.green_out),
	.blue_out  (result.blue_out),
	.clamped   (result.clamped)
);

>>> tb/rgc_checker.sv
`timescale 1ns / 1ps

module rgc_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  rgc_pkg::gain_t cfg_wdata,
	rgc_pixel_if.monitor   pixel,
	rgc_result_if.monitor  result,
	output int             fails,
	output int             pending
);
	import rgc_pkg::*;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  clamped;
	} shade_t;

	shade_t owed_q[$];
	shade_t head;
	gain_t  gain_copy;
	int     miss_cnt = 0;

	assign fails = miss_cnt;

	// Scales one pixel by the gain, or by 255 over its brightest channel if that one overflows.
	function automatic shade_t brighten(gain_t g, chan_t r, chan_t gr, chan_t b);
		int unsigned ch[3];
		int unsigned res[3];
		int unsigned m;
		shade_t s;
		ch[0] = r;
		ch[1] = gr;
		ch[2] = b;
		m = ch[0];
		if (ch[1] > m) begin
			m = ch[1];
		end
		if (ch[2] > m) begin
			m = ch[2];
		end
		s.clamped = (m * g) > LIMIT;
		for (int i = 0; i < 3; i++) begin
			if (s.clamped) begin
				res[i] = (ch[i] * FULL_SCALE) / m;
			end else begin
				res[i] = (ch[i] * g) >> FRAC_W;
			end
		end
		s.red   = chan_t'(res[0]);
		s.green = chan_t'(res[1]);
		s.blue  = chan_t'(res[2]);
		return s;
	endfunction

	task automatic report_miss(string msg);
		$display("rgc_checker: %0t ns: %s", $time, msg);
		miss_cnt++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q.delete();
			gain_copy <= GAIN_RESET;
			pending   <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (owed_q.size() == 0) begin
					report_miss($sformatf("result beat %0d/%0d/%0d/%0d with nothing owed",
						result.red_out, result.green_out, result.blue_out, result.clamped));
				end else begin
					head = owed_q.pop_front();
					if (result.red_out !== head.red) begin
						report_miss($sformatf("red_out %0d, expected %0d",
							result.red_out, head.red));
					end
					if (result.green_out !== head.green) begin
						report_miss($sformatf("green_out %0d, expected %0d",
							result.green_out, head.green));
					end
					if (result.blue_out !== head.blue) begin
						report_miss($sformatf("blue_out %0d, expected %0d",
							result.blue_out, head.blue));
					end
					if (result.clamped !== head.clamped) begin
						report_miss($sformatf("clamped %0d, expected %0d",
							result.clamped, head.clamped));
					end
				end
			end
			if (pixel.valid && pixel.ready) begin
				owed_q.insert(owed_q.size(), brighten(gain_copy, pixel.red_in,
					pixel.green_in, pixel.blue_in));
			end
			if (cfg_we) begin
				gain_copy <= cfg_wdata;
			end
			pending <= owed_q.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import rgc_pkg::*;

	localparam int STUCK_LIMIT  = 2000;
	localparam int STALL_CYCLES = 64;
	localparam int PHASE_ITEMS  = 133;
	localparam int RAND_GAIN    = -1;
	localparam int LOW_GAIN     = -2;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cfg_we;
	gain_t cfg_wdata;
	logic  stall_req;
	int    tx_idle_pct;
	int    rx_idle_pct;
	int    chk_fails;
	int    chk_pending;
	int    stuck_cycles = 0;
	int    pixels_sent = 0;
	int    gain_writes = 0;
	int    gain_plan[12];

	rgc_pixel_if  pixel_ch ();
	rgc_result_if result_ch ();

	rgb_gain_with_ratio_clamp dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pixel     (pixel_ch.sink),
		.result    (result_ch.source)
	);

	rgc_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pixel     (pixel_ch.monitor),
		.result    (result_ch.monitor),
		.fails     (chk_fails),
		.pending   (chk_pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic send_pixel(int r, int g, int b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			pixel_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pixel_ch.valid    <= 1'b1;
		pixel_ch.red_in   <= chan_t'(r);
		pixel_ch.green_in <= chan_t'(g);
		pixel_ch.blue_in  <= chan_t'(b);
		@(posedge clk);
		while (!pixel_ch.ready) begin
			@(posedge clk);
		end
		pixels_sent++;
	endtask

	task automatic drain();
		pixel_ch.valid <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_gain(int g);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= gain_t'(g);
		@(posedge clk);
		cfg_we <= 1'b0;
		gain_writes++;
	endtask

	task automatic run_phase(int g, int n);
		int kind;
		int t;
		int m;
		int pos;
		int ch[3];
		set_gain(g);
		for (int k = 0; k < n; k++) begin
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				for (int i = 0; i < 3; i++) begin
					ch[i] = $urandom_range(0, 255);
				end
			end else if (kind <= 8) begin
				// Put the brightest channel within one of the overflow threshold of this gain.
				if (g == 0) begin
					t = $urandom_range(0, 255);
				end else begin
					t = int'(LIMIT) / g;
				end
				m = t + $urandom_range(0, 2) - 1;
				if (m > 255) begin
					m = 255;
				end
				if (m < 0) begin
					m = 0;
				end
				pos = $urandom_range(0, 2);
				for (int i = 0; i < 3; i++) begin
					ch[i] = (i == pos) ? m : $urandom_range(0, m);
				end
			end else begin
				for (int i = 0; i < 3; i++) begin
					ch[i] = $urandom_range(0, 1) ? 255 : 0;
				end
			end
			send_pixel(ch[0], ch[1], ch[2]);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				stuck_cycles <= 0;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
			if (stuck_cycles == STUCK_LIMIT) begin
				$display("tb_top: no beat moved for %0d cycles", STUCK_LIMIT);
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int stall_left;
		bit stall_taken;
		stall_left  = 0;
		stall_taken = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if (stall_req && !stall_taken) begin
				stall_taken = 1'b1;
				stall_left  = STALL_CYCLES - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		int g;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		stall_req         <= 1'b0;
		tx_idle_pct       <= 0;
		rx_idle_pct       <= 30;
		pixel_ch.valid    <= 1'b0;
		pixel_ch.red_in   <= '0;
		pixel_ch.green_in <= '0;
		pixel_ch.blue_in  <= '0;
		gain_plan = '{4095, RAND_GAIN, 256, LOW_GAIN, 0, RAND_GAIN,
			1280, 4095, RAND_GAIN, 1, LOW_GAIN, 1536};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// At the reset gain of 6.0 the threshold lies between 42 and 43.
		send_pixel(0, 0, 0);
		send_pixel(255, 255, 255);
		send_pixel(255, 0, 0);
		send_pixel(0, 255, 0);
		send_pixel(0, 0, 255);
		send_pixel(42, 17, 3);
		send_pixel(43, 10, 1);
		send_pixel(1, 1, 1);
		send_pixel(128, 64, 32);
		// A product of exactly 255 * 256 saturates without clamping.
		set_gain(1280);
		send_pixel(51, 0, 0);
		send_pixel(0, 51, 50);
		send_pixel(52, 51, 0);
		send_pixel(0, 0, 52);
		set_gain(0);
		send_pixel(255, 255, 255);
		send_pixel(1, 2, 3);
		set_gain(4095);
		send_pixel(1, 0, 0);
		send_pixel(0, 0, 0);
		send_pixel(255, 128, 1);
		send_pixel(16, 15, 16);
		set_gain(256);
		send_pixel(255, 255, 255);
		send_pixel(254, 1, 0);

		for (int p = 0; p < 12; p++) begin
			drain();
			case (p / 4)
				0: begin
					tx_idle_pct <= 24;
					rx_idle_pct <= 66;
				end
				1: begin
					tx_idle_pct <= 66;
					rx_idle_pct <= 24;
				end
				default: begin
					tx_idle_pct <= 0;
					rx_idle_pct <= 0;
				end
			endcase
			if (p == 9) begin
				stall_req <= 1'b1;
			end
			g = gain_plan[p];
			if (g == RAND_GAIN) begin
				g = $urandom_range(0, 4095);
			end else if (g == LOW_GAIN) begin
				g = $urandom_range(64, 1024);
			end
			run_phase(g, PHASE_ITEMS);
		end

		drain();
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		$display("tb_top: %0d pixels through %0d gain writes, with sender and receiver idling",
			pixels_sent, gain_writes);
		$display("tb_top: and one %0d-cycle output stall; %0d mismatches", STALL_CYCLES, chk_fails);
		if (chk_fails == 0 && chk_pending == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
